// ----- hdl/mse_pkg.sv -----
package mse_pkg;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               empty_res;
    logic               overflow;
  } out_item_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH_RD,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_WR,
    ST_MRG_SETUP,
    ST_MRG_RD,
    ST_MRG_RD_B,
    ST_MRG_CMP,
    ST_CPY_RD,
    ST_CPY_WR
  } state_t;

endpackage

// ----- hdl/merge_sort_engine.sv -----
// merge_sort_engine: sorts a batch of signed 32-bit values into ascending order.
// Input channel (in_valid/in_ready/in_data): op 0 loads one value, op 1 fetches
// the next sorted value. A load with last set ends the batch and starts the sort.
// Output channel (out_valid/out_ready/out_data): one transaction per fetch;
// loads produce none.
// Loads that do not end the batch are taken back to back. A fetch reads memory
// in ST_FETCH_RD, which registers out_valid (an empty fetch sets it straight from
// ST_IDLE); the next input transaction is taken the cycle after the result leaves.
// The sort holds in_ready low after the last load: insertion sort of each run
// reads each element, shifts up to RUN_LENGTH-1 larger ones, then writes it, and
// each merge pass reads two heads, compares and writes scratch per element, then
// reads scratch and copies back, over ceil(log2(n/RUN_LENGTH)) passes.
// All data lives in one data memory and one scratch memory, each with one read
// port, one write port and a registered read.
// Reset clears the counters and flags; the memories are not cleared.
// While out_valid waits for out_ready, in_ready stays low.
module merge_sort_engine #(
  parameter int DEPTH      = 4096,
  parameter int RUN_LENGTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mse_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mse_pkg::out_item_t  out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + 1;

  logic signed [31:0] dmem [DEPTH];
  logic signed [31:0] smem [DEPTH];

  mse_pkg::state_t state, state_next;
  logic [CW-1:0] item_count;
  logic [CW-1:0] read_pointer;
  logic sorted_ready, dropped_flag;

  logic [PW-1:0] i, j, lo, hi, mid, k, step;
  logic signed [31:0] v, a;
  logic signed [31:0] drd, srd;

  logic          d_we;
  logic [AW-1:0] d_wa, d_ra;
  logic signed [31:0] d_wd;
  logic          s_we;
  logic [AW-1:0] s_wa, s_ra;
  logic signed [31:0] s_wd;

  logic in_fire, out_fire;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (state == mse_pkg::ST_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (d_we) dmem[d_wa] <= d_wd;
    drd <= dmem[d_ra];
    if (s_we) smem[s_wa] <= s_wd;
    srd <= smem[s_ra];
  end

  logic [CW-1:0] base_cnt;
  assign base_cnt = sorted_ready ? '0 : item_count;

  always_comb begin
    state_next = state;
    case (state)
      mse_pkg::ST_IDLE: begin
        if (in_fire && in_data.op == mse_pkg::OP_FETCH &&
            sorted_ready && read_pointer < item_count)
          state_next = mse_pkg::ST_FETCH_RD;
        else if (in_fire && in_data.op == mse_pkg::OP_LOAD && in_data.last)
          state_next = mse_pkg::ST_INS_RD;
      end
      mse_pkg::ST_FETCH_RD:  state_next = mse_pkg::ST_IDLE;
      mse_pkg::ST_INS_RD: begin
        if (i >= hi) begin
          if (hi >= PW'(item_count)) state_next = mse_pkg::ST_MRG_SETUP;
        end else state_next = mse_pkg::ST_INS_CMP;
      end
      mse_pkg::ST_INS_CMP: begin
        if (!(j > lo && drd > v)) state_next = mse_pkg::ST_INS_WR;
      end
      mse_pkg::ST_INS_WR:    state_next = mse_pkg::ST_INS_RD;
      mse_pkg::ST_MRG_SETUP: begin
        if (step >= PW'(item_count)) state_next = mse_pkg::ST_IDLE;
        else if (lo + step >= PW'(item_count)) state_next = mse_pkg::ST_MRG_SETUP;
        else state_next = mse_pkg::ST_MRG_RD;
      end
      mse_pkg::ST_MRG_RD:   state_next = mse_pkg::ST_MRG_RD_B;
      mse_pkg::ST_MRG_RD_B: state_next = mse_pkg::ST_MRG_CMP;
      mse_pkg::ST_MRG_CMP: begin
        if (k + 1'b1 >= hi) state_next = mse_pkg::ST_CPY_RD;
        else state_next = mse_pkg::ST_MRG_RD;
      end
      mse_pkg::ST_CPY_RD:  state_next = mse_pkg::ST_CPY_WR;
      mse_pkg::ST_CPY_WR: begin
        if (k + 1'b1 >= hi) state_next = mse_pkg::ST_MRG_SETUP;
        else state_next = mse_pkg::ST_CPY_RD;
      end
      default: state_next = mse_pkg::ST_IDLE;
    endcase
  end

  logic take_a;
  assign take_a = (i < mid) && (!(j < hi) || a <= drd);

  always_comb begin
    d_we = 1'b0;
    d_wa = '0;
    d_wd = '0;
    d_ra = '0;
    s_we = 1'b0;
    s_wa = '0;
    s_wd = '0;
    s_ra = '0;
    case (state)
      mse_pkg::ST_IDLE: begin
        d_ra = AW'(read_pointer);
        if (in_fire && in_data.op == mse_pkg::OP_LOAD && base_cnt < CW'(DEPTH)) begin
          d_we = 1'b1;
          d_wa = AW'(base_cnt);
          d_wd = in_data.value;
        end
      end
      mse_pkg::ST_INS_RD: begin
        if (i >= hi) d_ra = AW'(i + 1'b1);
        else d_ra = AW'(j - 1'b1);
      end
      mse_pkg::ST_INS_CMP: begin
        if (j > lo && drd > v) begin
          d_we = 1'b1;
          d_wa = AW'(j);
          d_wd = drd;
          d_ra = AW'(j - 2'd2);
        end
      end
      mse_pkg::ST_INS_WR: begin
        d_we = 1'b1;
        d_wa = AW'(j);
        d_wd = v;
        d_ra = AW'(i + 1'b1);
      end
      mse_pkg::ST_MRG_RD:   d_ra = AW'(i);
      mse_pkg::ST_MRG_RD_B: d_ra = AW'(j);
      mse_pkg::ST_MRG_CMP: begin
        s_we = 1'b1;
        s_wa = AW'(k);
        s_wd = take_a ? a : drd;
      end
      mse_pkg::ST_CPY_RD: s_ra = AW'(k);
      mse_pkg::ST_CPY_WR: begin
        d_we = 1'b1;
        d_wa = AW'(k);
        d_wd = srd;
      end
      default: ;
    endcase
  end

  logic [PW-1:0] run_end;
  always_comb begin
    run_end = i + PW'(RUN_LENGTH);
    if (run_end > PW'(item_count)) run_end = PW'(item_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mse_pkg::ST_IDLE;
      item_count   <= '0;
      read_pointer <= '0;
      sorted_ready <= 1'b0;
      dropped_flag <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_fire) out_valid <= 1'b0;
      case (state)
        mse_pkg::ST_IDLE: begin
          if (in_fire && in_data.op == mse_pkg::OP_LOAD) begin
            if (sorted_ready) begin
              sorted_ready <= 1'b0;
              read_pointer <= '0;
            end
            if (base_cnt < CW'(DEPTH)) begin
              item_count   <= base_cnt + 1'b1;
              dropped_flag <= sorted_ready ? 1'b0 : dropped_flag;
            end else begin
              item_count   <= base_cnt;
              dropped_flag <= 1'b1;
            end
            if (in_data.last) begin
              lo <= '0;
              hi <= '0;
              i  <= '0;
              j  <= '0;
            end
          end else if (in_fire) begin
            if (sorted_ready && read_pointer < item_count) begin
              read_pointer <= read_pointer + 1'b1;
            end else begin
              out_valid <= 1'b1;
              out_data  <= '{sorted_value: '0, final_res: 1'b0,
                             empty_res: 1'b1, overflow: 1'b0};
            end
          end
        end
        mse_pkg::ST_FETCH_RD: begin
          out_valid <= 1'b1;
          out_data  <= '{sorted_value: drd, final_res: (read_pointer == item_count),
                         empty_res: 1'b0, overflow: dropped_flag};
        end
        mse_pkg::ST_INS_RD: begin
          if (i >= hi) begin
            i <= i + 1'b1;
            j <= i + 1'b1;
            if (hi >= PW'(item_count)) begin
              step <= PW'(RUN_LENGTH);
              lo   <= '0;
            end else begin
              lo <= i;
              hi <= run_end;
            end
          end else begin
            v <= drd;
          end
        end
        mse_pkg::ST_INS_CMP: begin
          if (j > lo && drd > v) j <= j - 1'b1;
        end
        mse_pkg::ST_INS_WR: begin
          i <= i + 1'b1;
          j <= i + 1'b1;
        end
        mse_pkg::ST_MRG_SETUP: begin
          if (lo + step >= PW'(item_count)) begin
            lo   <= '0;
            step <= step << 1;
          end else begin
            mid <= lo + step;
            i   <= lo;
            j   <= lo + step;
            k   <= lo;
            hi  <= (PW'(item_count) - lo > (step << 1)) ? lo + (step << 1)
                                                        : PW'(item_count);
          end
        end
        mse_pkg::ST_MRG_RD_B: a <= drd;
        mse_pkg::ST_MRG_CMP: begin
          if (take_a) i <= i + 1'b1;
          else j <= j + 1'b1;
          if (k + 1'b1 >= hi) k <= lo;
          else k <= k + 1'b1;
        end
        mse_pkg::ST_CPY_WR: begin
          k <= k + 1'b1;
          if (k + 1'b1 >= hi) lo <= hi;
        end
        default: ;
      endcase
      if (state == mse_pkg::ST_INS_RD && i >= hi && hi >= PW'(item_count)) begin
        sorted_ready <= 1'b1;
        read_pointer <= '0;
      end
    end
  end

endmodule

// ----- hdl/mse_checker.sv -----
module mse_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input mse_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input mse_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.empty_res |-> !out_data.final_res && !out_data.overflow)
    else $error("empty result carries flags");

  a_load_no_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.op == mse_pkg::OP_LOAD |=> !out_valid)
    else $error("load produced a result");

endmodule

bind merge_sort_engine mse_port_checker u_mse_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
